### rtl/core/mfa_pkg.sv
// shared types and constants of the montgomery field alu
package mfa_pkg;

  localparam int LIMB_COUNT = 4;
  localparam int LIMB_W     = 64;
  localparam int DIGIT_W    = 32;
  localparam int WORD_W     = LIMB_COUNT * LIMB_W;
  localparam int ACC_W      = 2 * WORD_W;
  localparam int WORD_DIGS  = WORD_W / DIGIT_W;
  localparam int LIMB_DIGS  = LIMB_W / DIGIT_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MINV     = 3'd4;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_NEG = 2'd3
  } mode_t;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic  vld;
    mode_t mode;
    word_t lin;
    logic  flag;
  } side_t;

endpackage

### rtl/core/mfa_channels.sv
// operand, result and configuration channel interfaces
interface mfa_in_if import mfa_pkg::*; ();
  logic  valid;
  logic  ready;
  logic [1:0] mode;
  limb_t a_limb0;
  limb_t a_limb1;
  limb_t a_limb2;
  limb_t a_limb3;
  limb_t b_limb0;
  limb_t b_limb1;
  limb_t b_limb2;
  limb_t b_limb3;
  modport source(output valid, mode, a_limb0, a_limb1, a_limb2, a_limb3,
                 b_limb0, b_limb1, b_limb2, b_limb3, input ready);
  modport sink(input valid, mode, a_limb0, a_limb1, a_limb2, a_limb3,
               b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

interface mfa_out_if import mfa_pkg::*; ();
  logic  valid;
  logic  ready;
  limb_t r_limb0;
  limb_t r_limb1;
  limb_t r_limb2;
  limb_t r_limb3;
  modport source(output valid, r_limb0, r_limb1, r_limb2, r_limb3, input ready);
  modport sink(input valid, r_limb0, r_limb1, r_limb2, r_limb3, output ready);
endinterface

interface mfa_cfg_if import mfa_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  limb_t data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/mfa_product.sv
// three-stage 256x256 schoolbook product, its first stage being the entry stage
module mfa_product import mfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  mode_t mode,
  input  word_t a,
  input  word_t b,
  input  word_t modulus,
  output side_t side,
  output acc_t  acc
);

  logic [2*DIGIT_W-1:0] pp      [WORD_DIGS][WORD_DIGS];
  logic [2*DIGIT_W-1:0] pp_next [WORD_DIGS][WORD_DIGS];
  side_t side1, side1_next, side2;
  acc_t  sum2 [4];
  acc_t  sum2_next [4];

  always_comb begin
    logic [WORD_W:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    side1_next.vld  = in_vld;
    side1_next.mode = mode;
    unique case (mode)
      MODE_ADD: begin
        side1_next.lin  = a + b;
        side1_next.flag = 1'b0;
      end
      MODE_SUB: begin
        side1_next.lin  = diff[WORD_W-1:0];
        side1_next.flag = diff[WORD_W];
      end
      MODE_NEG: begin
        side1_next.lin  = modulus - a;
        side1_next.flag = |a;
      end
      MODE_MUL: begin
        side1_next.lin  = '0;
        side1_next.flag = 1'b0;
      end
      default: begin
        side1_next.lin  = '0;
        side1_next.flag = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < WORD_DIGS; j++) begin
      for (int m = 0; m < WORD_DIGS; m++) begin
        pp_next[j][m] = a[DIGIT_W*j +: DIGIT_W] * b[DIGIT_W*m +: DIGIT_W];
      end
    end
  end

  // rows of non-overlapping partial products, four rows per group
  always_comb begin
    acc_t rowv;
    for (int g = 0; g < 4; g++) begin
      sum2_next[g] = '0;
    end
    for (int j = 0; j < WORD_DIGS; j++) begin
      for (int p = 0; p < 2; p++) begin
        rowv = '0;
        for (int q = 0; q < WORD_DIGS/2; q++) begin
          rowv[DIGIT_W*(j+p) + 2*DIGIT_W*q +: 2*DIGIT_W] = pp[j][p+2*q];
        end
        sum2_next[j>>1] = sum2_next[j>>1] + rowv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.vld <= 1'b0;
      side2.vld <= 1'b0;
      side.vld  <= 1'b0;
    end else if (en) begin
      side1 <= side1_next;
      side2 <= side1;
      side  <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp   <= pp_next;
      sum2 <= sum2_next;
      acc  <= sum2[0] + sum2[1] + sum2[2] + sum2[3];
    end
  end

endmodule

### rtl/core/mfa_reduce_step.sv
// one five-stage word of montgomery reduction, window shifts down one limb
module mfa_reduce_step import mfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  limb_t minv,
  input  word_t modulus,
  input  side_t side_i,
  input  acc_t  acc_i,
  output side_t side_o,
  output acc_t  acc_o
);

  localparam int P_W = WORD_W + LIMB_W;

  side_t side_a, side_b, side_c, side_d;
  acc_t  acc_a, acc_b, acc_c, acc_d;
  limb_t kll;
  logic [DIGIT_W-1:0] klh, khl;
  limb_t k;
  logic [2*DIGIT_W-1:0] ppk      [LIMB_DIGS][WORD_DIGS];
  logic [2*DIGIT_W-1:0] ppk_next [LIMB_DIGS][WORD_DIGS];
  logic [P_W-1:0] prod, prod_next;
  limb_t kll_next;
  logic [DIGIT_W-1:0] klh_next, khl_next;
  acc_t  acc_sum;

  assign kll_next = acc_i[DIGIT_W-1:0] * minv[DIGIT_W-1:0];
  assign klh_next = acc_i[DIGIT_W-1:0] * minv[LIMB_W-1:DIGIT_W];
  assign khl_next = acc_i[LIMB_W-1:DIGIT_W] * minv[DIGIT_W-1:0];

  always_comb begin
    for (int j = 0; j < LIMB_DIGS; j++) begin
      for (int m = 0; m < WORD_DIGS; m++) begin
        ppk_next[j][m] = k[DIGIT_W*j +: DIGIT_W] * modulus[DIGIT_W*m +: DIGIT_W];
      end
    end
  end

  always_comb begin
    logic [P_W-1:0] rowv;
    prod_next = '0;
    for (int j = 0; j < LIMB_DIGS; j++) begin
      for (int p = 0; p < 2; p++) begin
        rowv = '0;
        for (int q = 0; q < WORD_DIGS/2; q++) begin
          rowv[DIGIT_W*(j+p) + 2*DIGIT_W*q +: 2*DIGIT_W] = ppk[j][p+2*q];
        end
        prod_next = prod_next + rowv;
      end
    end
  end

  assign acc_sum = acc_d + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a.vld <= 1'b0;
      side_b.vld <= 1'b0;
      side_c.vld <= 1'b0;
      side_d.vld <= 1'b0;
      side_o.vld <= 1'b0;
    end else if (en) begin
      side_a <= side_i;
      side_b <= side_a;
      side_c <= side_b;
      side_d <= side_c;
      side_o <= side_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_a <= acc_i;
      kll   <= kll_next;
      klh   <= klh_next;
      khl   <= khl_next;
      acc_b <= acc_a;
      k     <= kll + {klh + khl, {DIGIT_W{1'b0}}};
      acc_c <= acc_b;
      ppk   <= ppk_next;
      acc_d <= acc_c;
      prod  <= prod_next;
      acc_o <= acc_sum >> LIMB_W;
    end
  end

endmodule

### rtl/core/montgomery_field_alu.sv
// top level of the pipelined montgomery field alu
//
// op carries one operation per beat: mode (add, subtract, multiply, negate)
// and operands a and b as four 64-bit limbs, least significant first.
// res returns one 256-bit result per accepted beat, in order.
// cfg writes the modulus limbs (index 0 to 3) and the negated inverse of
// the modulus mod 2^64 (index 4); write it only while no beat is in flight.
// every mode takes the same path from op beat to res valid: the entry stage,
// two product summing stages, four reduction words of five stages each and
// the final conditional correction stage.
// one beat enters per cycle while res is not stalled; the whole pipeline advances together.
// reset empties the pipeline and clears the configuration to zero.
// when res is stalled the pipeline holds and op.ready drops; nothing is
// lost or repeated, and bubbles stay in place.
module montgomery_field_alu import mfa_pkg::*; (
  input logic clk,
  input logic rst,
  mfa_in_if.sink    op,
  mfa_out_if.source res,
  mfa_cfg_if.sink   cfg
);

  limb_t modulus_limb [LIMB_COUNT];
  limb_t minv;
  word_t modulus;
  logic  en;
  side_t red_side [LIMB_COUNT+1];
  acc_t  red_acc  [LIMB_COUNT+1];
  logic  res_vld;
  word_t res_data, r_next, v;
  logic [WORD_W:0] vmn;
  word_t vpn;

  assign modulus = {modulus_limb[3], modulus_limb[2], modulus_limb[1], modulus_limb[0]};

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIMB_COUNT; i++) begin
        modulus_limb[i] <= '0;
      end
      minv <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MODULUS0: modulus_limb[0] <= cfg.data;
        CFG_MODULUS1: modulus_limb[1] <= cfg.data;
        CFG_MODULUS2: modulus_limb[2] <= cfg.data;
        CFG_MODULUS3: modulus_limb[3] <= cfg.data;
        CFG_MINV:     minv            <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en       = !res_vld || res.ready;
  assign op.ready = en;

  mfa_product u_product (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (op.valid),
    .mode    (mode_t'(op.mode)),
    .a       ({op.a_limb3, op.a_limb2, op.a_limb1, op.a_limb0}),
    .b       ({op.b_limb3, op.b_limb2, op.b_limb1, op.b_limb0}),
    .modulus (modulus),
    .side    (red_side[0]),
    .acc     (red_acc[0])
  );

  for (genvar i = 0; i < LIMB_COUNT; i++) begin : g_reduce
    mfa_reduce_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .minv    (minv),
      .modulus (modulus),
      .side_i  (red_side[i]),
      .acc_i   (red_acc[i]),
      .side_o  (red_side[i+1]),
      .acc_o   (red_acc[i+1])
    );
  end

  assign v   = (red_side[LIMB_COUNT].mode == MODE_MUL) ?
               red_acc[LIMB_COUNT][WORD_W-1:0] : red_side[LIMB_COUNT].lin;
  assign vmn = {1'b0, v} - {1'b0, modulus};
  assign vpn = v + modulus;

  always_comb begin
    unique case (red_side[LIMB_COUNT].mode)
      MODE_ADD, MODE_MUL: r_next = vmn[WORD_W] ? v : vmn[WORD_W-1:0];
      MODE_SUB:           r_next = red_side[LIMB_COUNT].flag ? vpn : v;
      MODE_NEG:           r_next = red_side[LIMB_COUNT].flag ? v : '0;
      default:            r_next = v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (en) begin
      res_vld <= red_side[LIMB_COUNT].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= r_next;
    end
  end

  assign res.valid   = res_vld;
  assign res.r_limb0 = res_data[0*LIMB_W +: LIMB_W];
  assign res.r_limb1 = res_data[1*LIMB_W +: LIMB_W];
  assign res.r_limb2 = res_data[2*LIMB_W +: LIMB_W];
  assign res.r_limb3 = res_data[3*LIMB_W +: LIMB_W];

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> $stable(red_side[LIMB_COUNT]))
    else $error("last reduction stage moved during a stall");

  a_product_arrives: assert property (@(posedge clk) disable iff (rst)
    (op.valid && op.ready) ##1 op.ready ##1 op.ready |=> red_side[0].vld)
    else $error("accepted beat missing at product output");

endmodule
